[design/dawg_pkg.sv]
package dawg_pkg;

  localparam int ADDR_IN_W = 16;
  localparam int WORD_W    = 32;
  localparam int LETTER_W  = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                 is_check;
    logic [ADDR_IN_W-1:0] node_address;
    logic [WORD_W-1:0]    node_word;
    logic [LETTER_W-1:0]  letter;
    logic                 last_letter;
  } dawg_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

endpackage

[design/dawg_if.sv]
interface dawg_in_if;
  import dawg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ADDR_IN_W-1:0] node_address;
  logic [WORD_W-1:0]    node_word;
  logic [LETTER_W-1:0]  letter;
  logic                 last_letter;

  modport source (
    output valid, command, node_address, node_word, letter, last_letter,
    input  ready
  );
  modport sink (
    input  valid, command, node_address, node_word, letter, last_letter,
    output ready
  );
endinterface

interface dawg_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink (input valid, found, output ready);
endinterface

[design/dawg_ram.sv]
module dawg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/dawg_front.sv]
module dawg_front (
  input  logic                clk,
  input  logic                rst,
  dawg_in_if.sink             query,
  output dawg_pkg::dawg_item_t item,
  output logic                item_valid,
  input  logic                item_ready
);
  import dawg_pkg::*;

  dawg_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  dawg_item_t        incoming;

  assign query.ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign item_valid  = (count != '0);
  assign item        = entries[rd_ptr];
  assign push        = query.valid && query.ready;
  assign pop         = item_valid && item_ready;

  always_comb begin
    incoming.is_check     = (query.command == CMD_CHECK);
    incoming.node_address = query.node_address;
    incoming.node_word    = query.node_word;
    incoming.letter       = query.letter;
    incoming.last_letter  = query.last_letter;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/dawg_back.sv]
module dawg_back #(
  parameter int NODE_COUNT   = 65536,
  parameter int ROOT_INDEX   = 1,
  parameter int LETTER_SHIFT = 24,
  parameter int POINTER_BITS = 16,
  parameter int WORD_END_BIT = 23,
  parameter int NODE_END_BIT = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dawg_pkg::dawg_item_t item,
  input  logic                 item_valid,
  output logic                 item_ready,
  dawg_out_if.source           answer
);
  import dawg_pkg::*;

  localparam int AW  = $clog2(NODE_COUNT);
  localparam int IW0 = (POINTER_BITS > ADDR_IN_W) ? POINTER_BITS : ADDR_IN_W;
  localparam int IW  = (AW + 1 > IW0) ? AW + 1 : IW0;
  localparam logic [IW-1:0] NODE_LIM = IW'(NODE_COUNT);
  localparam logic [IW-1:0] ROOT_VAL = IW'(ROOT_INDEX);

  back_state_t         state;
  back_state_t         state_next;
  logic [IW-1:0]       current_edge;
  logic [IW-1:0]       current_edge_next;
  logic                word_failed;
  logic                word_failed_next;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       idx_next;
  logic [LETTER_W-1:0] cur_letter;
  logic                cur_last;
  logic                out_valid;
  logic                found;
  logic                found_next;
  logic                push;
  logic                can_take;

  logic                we;
  logic                re;
  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       load_idx;
  logic [WORD_W-1:0]   rdata;
  logic [63:0]         edge_ext;
  logic [LETTER_W-1:0] edge_letter;
  logic                edge_word_end;
  logic                edge_node_end;
  logic [IW-1:0]       edge_child;
  logic [IW-1:0]       idx_inc;

  dawg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (load_idx[AW-1:0]),
    .wdata (item.node_word),
    .re    (re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // Edge fields are taken from the word zero-extended to 64 bits.
  assign edge_ext      = 64'(rdata);
  assign edge_letter   = edge_ext[LETTER_SHIFT +: LETTER_W];
  assign edge_word_end = edge_ext[WORD_END_BIT];
  assign edge_node_end = edge_ext[NODE_END_BIT];
  assign edge_child    = IW'(edge_ext[POINTER_BITS-1:0]);
  assign idx_inc       = idx + 1'b1;
  assign load_idx      = IW'(item.node_address);

  // A last letter is taken only when the result slot is free or draining,
  // so its answer can always be written when the scan ends.
  assign can_take = !item.is_check || !item.last_letter || !out_valid || answer.ready;

  assign answer.valid = out_valid;
  assign answer.found = found;

  always_comb begin
    state_next        = state;
    current_edge_next = current_edge;
    word_failed_next  = word_failed;
    idx_next          = idx;
    found_next        = 1'b0;
    push              = 1'b0;
    we                = 1'b0;
    re                = 1'b0;
    rd_idx            = current_edge;
    item_ready        = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = can_take;
        if (item_valid && can_take) begin
          if (!item.is_check) begin
            we = (load_idx < NODE_LIM);
          end else if (word_failed || (current_edge == '0) ||
                       !(current_edge < NODE_LIM)) begin
            if (item.last_letter) begin
              push              = 1'b1;
              current_edge_next = ROOT_VAL;
              word_failed_next  = 1'b0;
            end else begin
              word_failed_next = 1'b1;
            end
          end else begin
            re         = 1'b1;
            rd_idx     = current_edge;
            idx_next   = current_edge;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (edge_letter == cur_letter) begin
          state_next = ST_IDLE;
          if (cur_last) begin
            push              = 1'b1;
            found_next        = edge_word_end;
            current_edge_next = ROOT_VAL;
            word_failed_next  = 1'b0;
          end else if (edge_child == '0) begin
            word_failed_next = 1'b1;
          end else begin
            current_edge_next = edge_child;
          end
        end else if (edge_node_end || !(idx_inc < NODE_LIM)) begin
          state_next = ST_IDLE;
          if (cur_last) begin
            push              = 1'b1;
            current_edge_next = ROOT_VAL;
            word_failed_next  = 1'b0;
          end else begin
            word_failed_next = 1'b1;
          end
        end else begin
          re       = 1'b1;
          rd_idx   = idx_inc;
          idx_next = idx_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_edge <= ROOT_VAL;
      word_failed  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      current_edge <= current_edge_next;
      word_failed  <= word_failed_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (answer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (push) begin
      found <= found_next;
    end
    if (item_valid && item_ready) begin
      cur_letter <= item.letter;
      cur_last   <= item.last_letter;
    end
  end

  a_no_take_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !item_ready)
    else $error("item taken while a scan is running");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || answer.ready))
    else $error("result written over a pending result");

  a_back_to_root: assert property (@(posedge clk) disable iff (rst)
    push |=> ((current_edge == ROOT_VAL) && !word_failed))
    else $error("walk did not return to the root after a word");

endmodule

[design/dawg_exact_word_lookup.sv]
// Loads pass through the queue stage and are then written to the node memory.
// A check walks one sibling edge per cycle; a word already failed is answered without
// a memory read, else the answer follows the scan of the sibling edges.
// No new item is taken while a scan is running.
// The found result is held in an output register until its transfer.
// Synchronous reset empties the queue and output and returns the walk to the root.
module dawg_exact_word_lookup #(
  parameter int NODE_COUNT   = 65536,
  parameter int ROOT_INDEX   = 1,
  parameter int LETTER_SHIFT = 24,
  parameter int POINTER_BITS = 16,
  parameter int WORD_END_BIT = 23,
  parameter int NODE_END_BIT = 22
) (
  input logic        clk,
  input logic        rst,
  dawg_in_if.sink    query,
  dawg_out_if.source answer
);
  import dawg_pkg::*;

  dawg_item_t item;
  logic       item_valid;
  logic       item_ready;

  dawg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .query      (query),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  dawg_back #(
    .NODE_COUNT   (NODE_COUNT),
    .ROOT_INDEX   (ROOT_INDEX),
    .LETTER_SHIFT (LETTER_SHIFT),
    .POINTER_BITS (POINTER_BITS),
    .WORD_END_BIT (WORD_END_BIT),
    .NODE_END_BIT (NODE_END_BIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .answer     (answer)
  );

endmodule

[sim/tb_dawg_exact_word_lookup.sv]
`timescale 1ns / 100ps

module tb_dawg_exact_word_lookup;
  import dawg_pkg::*;

  localparam int NODES        = 65536;
  localparam int ROOT         = 1;
  localparam int LETTER_SHIFT = 24;
  localparam int POINTER_BITS = 16;
  localparam int WORD_END_BIT = 23;
  localparam int NODE_END_BIT = 22;
  localparam bit [63:0] PTR_MASK = (64'd1 << POINTER_BITS) - 64'd1;

  typedef struct {
    logic      cmd;
    bit [15:0] addr;
    bit [31:0] word;
    bit [7:0]  ch;
    bit        last;
    bit        drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dawg_in_if  query_if ();
  dawg_out_if answer_if ();

  dawg_exact_word_lookup #(
    .NODE_COUNT  (NODES),
    .ROOT_INDEX  (ROOT),
    .LETTER_SHIFT(LETTER_SHIFT),
    .POINTER_BITS(POINTER_BITS),
    .WORD_END_BIT(WORD_END_BIT),
    .NODE_END_BIT(NODE_END_BIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .query (query_if),
    .answer(answer_if)
  );

  always #5 clk = ~clk;

  stim_t       stim_q[$];
  bit          found_q[$];
  bit          results_drained = 1'b1;
  int unsigned accepted = 0;
  int unsigned fail_count = 0;
  int unsigned loads_seen = 0;
  int unsigned letters_seen = 0;
  int unsigned words_found = 0;
  int unsigned words_missed = 0;
  int unsigned dict_count = 0;

  // Predictor state: node memory as loaded so far and the position of the walk.
  bit [31:0]   dawg_mem[int unsigned];
  int unsigned walk_edge = ROOT;
  bit          walk_failed = 1'b0;

  function automatic bit [31:0] edge_word(input bit [7:0] ch, input bit end_word,
                                          input bit end_node, input bit [5:0] spare,
                                          input bit [15:0] child);
    return {ch, end_word, end_node, spare, child};
  endfunction

  function automatic void push_load(input int unsigned a, input bit [31:0] w);
    stim_q.push_back('{cmd: CMD_LOAD, addr: 16'(a), word: w, ch: 8'($urandom),
                       last: 1'($urandom), drain: 1'b0});
  endfunction

  function automatic void push_letter(input bit [7:0] ch, input bit last);
    stim_q.push_back('{cmd: CMD_CHECK, addr: 16'($urandom), word: $urandom, ch: ch,
                       last: last, drain: 1'b0});
  endfunction

  // Scans the sibling edges from the current walk position for a letter.
  function automatic bit find_edge(input bit [7:0] ch, output bit [63:0] hit);
    int unsigned idx;
    bit [63:0]   e;
    idx = walk_edge;
    hit = '0;
    if (idx == 0) return 1'b0;
    forever begin
      if (idx >= NODES) return 1'b0;
      if (!dawg_mem.exists(idx)) begin
        $error("walk reached node entry %0d that was never loaded", idx);
        fail_count++;
        return 1'b0;
      end
      e = 64'(dawg_mem[idx]);
      if (e[LETTER_SHIFT +: 8] == ch) begin
        hit = e;
        return 1'b1;
      end
      if (e[NODE_END_BIT]) return 1'b0;
      idx++;
    end
  endfunction

  task automatic lookup_step(input logic cmd, input bit [15:0] addr, input bit [31:0] w,
                             input bit [7:0] ch, input bit last);
    bit [63:0] e;
    bit        hit_found;
    hit_found = 1'b0;
    if (cmd == CMD_LOAD) begin
      loads_seen++;
      if (addr < NODES) dawg_mem[addr] = w;
      return;
    end
    letters_seen++;
    if (!walk_failed) begin
      if (!find_edge(ch, e)) walk_failed = 1'b1;
      else if (last) hit_found = e[WORD_END_BIT];
      else if ((e & PTR_MASK) == 0) walk_failed = 1'b1;
      else walk_edge = int'(e & PTR_MASK);
    end
    if (last) begin
      found_q.push_back(hit_found);
      walk_edge = ROOT;
      walk_failed = 1'b0;
    end
  endtask

  // Sender: bursts of transfers separated by random gaps; a phase boundary
  // waits until every outstanding result has been returned.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          drain_idle = 1'b0;

  always @(posedge clk) begin : drive
    stim_t it;
    if (rst) begin
      query_if.valid <= 1'b0;
    end else if (!query_if.valid || query_if.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        query_if.valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        query_if.valid <= 1'b0;
      end else if (stim_q[0].drain && !(drain_idle && results_drained)) begin
        // Go idle first, so the last transfer's result is already counted.
        drain_idle = 1'b1;
        query_if.valid <= 1'b0;
      end else begin
        it = stim_q.pop_front();
        drain_idle = 1'b0;
        query_if.valid        <= 1'b1;
        query_if.command      <= it.cmd;
        query_if.node_address <= it.addr;
        query_if.node_word    <= it.word;
        query_if.letter       <= it.ch;
        query_if.last_letter  <= it.last;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(60, 200);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: long runs of ready mixed with short runs and stalls.
  int unsigned run_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      answer_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      answer_if.ready <= 1'b0;
    end else begin
      answer_if.ready <= 1'b1;
      if (run_left != 0) begin
        run_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        run_left = $urandom_range(50, 250);
      end else begin
        run_left = $urandom_range(0, 6);
        stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin : observe
    bit want;
    if (!rst) begin
      if (answer_if.valid && answer_if.ready) begin
        if (found_q.size() == 0) begin
          $error("found: no result expected, got %0b", answer_if.found);
          fail_count++;
        end else begin
          want = found_q.pop_front();
          if (want) words_found++;
          else words_missed++;
          if (answer_if.found !== want) begin
            $error("found: expected %0b, got %0b", want, answer_if.found);
            fail_count++;
          end
        end
      end
      if (query_if.valid && query_if.ready) begin
        accepted++;
        lookup_step(query_if.command, query_if.node_address, query_if.node_word,
                    query_if.letter, query_if.last_letter);
      end
    end
    results_drained <= (found_q.size() == 0);
  end

  initial begin : stimulus
    int unsigned node_base[$];
    int unsigned node_len[$];
    int          node_at[int unsigned];
    bit [31:0]   dict[int unsigned];
    int unsigned total;
    int unsigned pos;
    int unsigned span;
    int unsigned a;
    int unsigned drain_at;
    int unsigned phase_end;
    int          n;
    int          k;
    bit [31:0]   w;
    bit [7:0]    ch;
    bit          cut;

    query_if.valid        = 1'b0;
    query_if.command      = CMD_LOAD;
    query_if.node_address = '0;
    query_if.node_word    = '0;
    query_if.letter       = '0;
    query_if.last_letter  = 1'b0;
    answer_if.ready       = 1'b0;

    // Small hand-built dictionary: root at 1, a child node at 10 and an
    // unterminated pair of edges at the very top of memory.
    push_load(16'h0000, 32'hFFFF_FFFF);
    push_load(1, edge_word(8'h63, 1'b0, 1'b0, 6'h00, 16'd10));
    push_load(2, edge_word(8'h00, 1'b1, 1'b0, 6'h15, 16'd0));
    push_load(3, edge_word(8'hFF, 1'b1, 1'b1, 6'h00, 16'hFFFE));
    push_load(10, edge_word(8'h61, 1'b1, 1'b0, 6'h00, 16'd0));
    push_load(11, edge_word(8'h74, 1'b0, 1'b1, 6'h00, 16'd0));
    push_load(16'hFFFE, edge_word(8'h79, 1'b0, 1'b0, 6'h3F, 16'd0));
    push_load(16'hFFFF, edge_word(8'h77, 1'b1, 1'b0, 6'h2A, 16'hFFFF));
    push_letter("c", 1'b1);
    push_letter("c", 1'b0); push_letter("a", 1'b1);
    push_letter("c", 1'b0); push_letter("t", 1'b1);
    // Child pointer of zero: the word fails and the trailing letter is ignored.
    push_letter("c", 1'b0); push_letter("a", 1'b0); push_letter("x", 1'b1);
    push_letter("q", 1'b1);
    push_letter(8'h00, 1'b1);
    push_letter("q", 1'b0); push_letter("a", 1'b1);
    // A miss in the top edges runs past the end of memory.
    push_letter(8'hFF, 1'b0); push_letter("z", 1'b1);
    push_letter(8'hFF, 1'b0); push_letter("w", 1'b0); push_letter("w", 1'b1);

    while (stim_q.size() + 200 < 1150) begin
      dict_count++;
      node_base.delete();
      node_len.delete();
      node_at.delete();
      dict.delete();
      span = $urandom_range(1, 26);
      node_base.push_back(ROOT);
      node_len.push_back(span);
      pos = ROOT + span;
      repeat ($urandom_range(12, 30)) begin
        pos += $urandom_range(0, 2200);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 26) : $urandom_range(1, 8);
        if (pos + span <= NODES - 6) begin
          node_base.push_back(pos);
          node_len.push_back(span);
          pos += span;
        end
      end
      node_base.push_back(NODES - 2);
      node_len.push_back(2);
      foreach (node_base[i]) node_at[node_base[i]] = i;

      // Every node ends with an end-of-node mark except the top pair, and every
      // child pointer names a node start, so no walk reaches an unloaded entry.
      drain_at = stim_q.size();
      foreach (node_base[i]) begin
        for (int j = 0; j < node_len[i]; j++) begin
          a = node_base[i] + j;
          w = edge_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        (j == node_len[i] - 1) && (i != node_base.size() - 1),
                        6'($urandom_range(0, 63)),
                        ($urandom_range(0, 3) == 0) ? 16'd0 :
                          16'(node_base[$urandom_range(0, node_base.size() - 1)]));
          dict[a] = w;
          push_load(a, w);
        end
      end
      stim_q[drain_at].drain = 1'b1;

      phase_end = stim_q.size() + $urandom_range(180, 300);
      if (phase_end > 1150) begin
        phase_end = (stim_q.size() + 40 > 1150) ? stim_q.size() + 40 : 1150;
      end
      while (stim_q.size() < phase_end) begin
        if ($urandom_range(0, 14) == 0) begin
          // Rewrite one edge in place, keeping its end-of-node mark.
          n = $urandom_range(0, node_base.size() - 1);
          a = node_base[n] + $urandom_range(0, node_len[n] - 1);
          w = edge_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        dict[a][NODE_END_BIT],
                        6'($urandom_range(0, 63)),
                        ($urandom_range(0, 3) == 0) ? 16'd0 :
                          16'(node_base[$urandom_range(0, node_base.size() - 1)]));
          dict[a] = w;
          push_load(a, w);
        end else begin
          // Mostly a path through the graph; now and then a stray letter, and
          // rarely a word that never gets its last letter.
          span = $urandom_range(1, 7);
          cut = ($urandom_range(0, 19) == 0);
          n = 0;
          for (k = 0; k < span; k++) begin
            if (n < 0 || $urandom_range(0, 7) == 0) begin
              ch = 8'($urandom_range(0, 255));
              n = -1;
            end else begin
              a = node_base[n] + $urandom_range(0, node_len[n] - 1);
              ch = dict[a][31:24];
              n = (dict[a][15:0] == 0) ? -1 : node_at[dict[a][15:0]];
            end
            push_letter(ch, (k == span - 1) && !cut);
          end
        end
      end
    end

    total = stim_q.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (accepted == total);
    while (found_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Run covered %0d node loads and %0d letter checks over %0d dictionaries.",
             loads_seen, letters_seen, dict_count + 1);
    $display("Words answered: %0d found, %0d not found.", words_found, words_missed);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d of the input transfers done.", accepted);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
